@@ design/lkm_pkg.sv @@
// ---------------------------------------------------------------------------
// lkm_pkg
// Shared types, constants and fixed-point helpers of the lateral kinematic
// model step pipeline.
// ---------------------------------------------------------------------------
package lkm_pkg;

   // default fraction width of the Q format
   localparam int FRAC_BITS_DEF = 16;

   // cordic setup: iterations, gain-compensated start value, turn scaling
   localparam int CORDIC_ITERS = 24;
   localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
   localparam logic [30:0]        TURN_SCALE  = 31'd683565276;

   // arctangent table in units of one turn over 2^32
   localparam logic [31:0] ATAN_TURN [0:CORDIC_ITERS-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // reciprocal of three for exact 32-bit floor division (shift 33)
   localparam logic [32:0] DIV3_RECIP = 33'h0AAAAAAAB;

   // configuration register map
   localparam int          CSR_ADDR_BITS  = 3;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_TIME_STEP = 3'd0;
   localparam logic [16:0] TIME_STEP_RESET = 17'd6554;

   // request payload
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] heading;
      logic signed [31:0] steer_angle;
      logic signed [31:0] steer_rate;
      logic signed [31:0] ref_vel;
      logic signed [31:0] curv_gain;
   } req_type;

   // response payload
   typedef struct packed {
      logic signed [31:0] next_x;
      logic signed [31:0] next_y;
      logic signed [31:0] next_heading;
      logic signed [31:0] next_steer;
      logic signed [31:0] dx_dheading;
      logic signed [31:0] dx_dsteer;
      logic signed [31:0] dy_dheading;
      logic signed [31:0] dy_dsteer;
      logic signed [31:0] dheading_dsteer;
   } rsp_type;

   // values carried alongside the cordic units
   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] nsteer;
      logic signed [31:0] dtv;
      logic signed [31:0] dtkv;
      logic signed [31:0] h;
      logic signed [31:0] th2;
   } side_type;

   // pipeline control handed to the cordic units
   typedef struct packed {
      logic advance;
   } pipe_ctl_type;

   // saturate to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // round to nearest, ties toward plus infinity, then arithmetic shift
   function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                               input int s);
      logic signed [63:0] r;
      r = v + (64'sd1 <<< (s - 1));
      return r >>> s;
   endfunction

   // fixed-point product, rounded and saturated
   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input int fb);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return sat32(rshr(p, fb));
   endfunction

endpackage

@@ design/lkm_cordic.sv @@
// ---------------------------------------------------------------------------
// lkm_cordic
// Pipelined sine/cosine: angle to turn phase, one rotation per stage,
// clamp and quadrant fold. Q30 results, fixed latency.
// ---------------------------------------------------------------------------
module lkm_cordic #(
   parameter int FRAC_BITS = lkm_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  lkm_pkg::pipe_ctl_type ctl,
   input  logic signed [31:0]   angle,
   output logic signed [31:0]   sin_q30,
   output logic signed [31:0]   cos_q30
);

   localparam int N = lkm_pkg::CORDIC_ITERS;

   logic signed [62:0] prod;
   logic [31:0]        phase;

   logic signed [33:0] x_ff [0:N];
   logic signed [33:0] y_ff [0:N];
   logic signed [31:0] z_ff [0:N];
   logic [1:0]         quad_ff [0:N];

   logic signed [33:0] xc;
   logic signed [33:0] yc;
   logic signed [31:0] sin_ff;
   logic signed [31:0] cos_ff;
   logic signed [31:0] sin_in;
   logic signed [31:0] cos_in;

   // angle to turn phase
   assign prod  = 63'(angle) * $signed({1'b0, lkm_pkg::TURN_SCALE});
   assign phase = prod[FRAC_BITS+31:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         x_ff[0]    <= lkm_pkg::CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= $signed({2'b00, phase[29:0]});
         quad_ff[0] <= phase[31:30];
      end
   end

   // one rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            if (!z_ff[i][31]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - $signed(lkm_pkg::ATAN_TURN[i]);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + $signed(lkm_pkg::ATAN_TURN[i]);
            end
            quad_ff[i+1] <= quad_ff[i];
         end
      end
   end

   // clamp to unit range and fold quadrant
   always_comb begin
      xc = x_ff[N];
      yc = y_ff[N];
      if (xc > lkm_pkg::Q30_ONE) xc = lkm_pkg::Q30_ONE;
      if (xc < -lkm_pkg::Q30_ONE) xc = -lkm_pkg::Q30_ONE;
      if (yc > lkm_pkg::Q30_ONE) yc = lkm_pkg::Q30_ONE;
      if (yc < -lkm_pkg::Q30_ONE) yc = -lkm_pkg::Q30_ONE;
      case (quad_ff[N])
         2'd0: begin
            cos_in = xc[31:0];
            sin_in = yc[31:0];
         end
         2'd1: begin
            cos_in = -yc[31:0];
            sin_in = xc[31:0];
         end
         2'd2: begin
            cos_in = -xc[31:0];
            sin_in = -yc[31:0];
         end
         default: begin
            cos_in = yc[31:0];
            sin_in = -xc[31:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_q30 = sin_ff;
   assign cos_q30 = cos_ff;

endmodule

@@ design/lateral_kinematic_model_step.sv @@
// ---------------------------------------------------------------------------
// lateral_kinematic_model_step
// One Runge-Kutta style step of a lateral kinematic vehicle model with the
// state Jacobian entries, fully pipelined in Q format fixed point.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  req_data (req_type)
//  rsp_      out        rsp_valid/rsp_stall  rsp_data (rsp_type)
//  csr_      in/out     apb psel/penable     time_step at byte address 0
//
// One request per cycle unless stalled; a request passes stages 1 to 4, the cordic units, then stages 5 to 9.
// Throughput is set by the single shared pipeline enable: every stage moves
// together unless a result sits in the output register with rsp_stall high.
// Reset clears valid bits and loads time_step with 6554; data regs are not reset.
// While stalled, req_stall is high and no stage changes.
module lateral_kinematic_model_step #(
   parameter int FRAC_BITS = lkm_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lkm_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lkm_pkg::rsp_type     rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [lkm_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam int LAT = lkm_pkg::CORDIC_LAT;

   logic                 advance;
   lkm_pkg::pipe_ctl_type ctl;
   logic [16:0]          dt_ff;
   logic signed [31:0]   dt;

   // configuration register
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= lkm_pkg::TIME_STEP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == lkm_pkg::ADDR_TIME_STEP) begin
         dt_ff <= csr_pwdata[16:0];
      end
   end
   assign csr_prdata = (csr_paddr == lkm_pkg::ADDR_TIME_STEP) ? {15'd0, dt_ff} : 32'd0;
   assign dt = $signed({15'd0, dt_ff});

   // global pipeline enable
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign ctl.advance = advance;

   // stage 1: first products
   logic vld1_ff;
   logic signed [31:0] kv1_ff, dt2_1_ff, dtv1_ff, dtw1_ff;
   logic signed [31:0] px1_ff, py1_ff, th1s_ff, d1_ff, w1_ff, v1_ff;
   always_ff @(posedge clock) begin
      if (reset) vld1_ff <= 1'b0;
      else if (advance) vld1_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         kv1_ff   <= lkm_pkg::mulq(req_data.curv_gain, req_data.ref_vel, FRAC_BITS);
         dt2_1_ff <= lkm_pkg::mulq(dt, dt, FRAC_BITS);
         dtv1_ff  <= lkm_pkg::mulq(dt, req_data.ref_vel, FRAC_BITS);
         dtw1_ff  <= lkm_pkg::mulq(dt, req_data.steer_rate, FRAC_BITS);
         px1_ff   <= req_data.pos_x;
         py1_ff   <= req_data.pos_y;
         th1s_ff  <= req_data.heading;
         d1_ff    <= req_data.steer_angle;
         w1_ff    <= req_data.steer_rate;
         v1_ff    <= req_data.ref_vel;
      end
   end

   // stage 2: second products, next steering
   logic vld2_ff;
   logic signed [31:0] dtkv2_ff, kvw2_ff, kvv2_ff, nst2_ff;
   logic signed [31:0] px2_ff, py2_ff, th2s_ff, d2_ff, dt2_2_ff, dtv2_ff;
   always_ff @(posedge clock) begin
      if (reset) vld2_ff <= 1'b0;
      else if (advance) vld2_ff <= vld1_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         dtkv2_ff <= lkm_pkg::mulq(dt, kv1_ff, FRAC_BITS);
         kvw2_ff  <= lkm_pkg::mulq(kv1_ff, w1_ff, FRAC_BITS);
         kvv2_ff  <= lkm_pkg::mulq(kv1_ff, v1_ff, FRAC_BITS);
         nst2_ff  <= lkm_pkg::sat32(64'(d1_ff) + 64'(dtw1_ff));
         px2_ff   <= px1_ff;
         py2_ff   <= py1_ff;
         th2s_ff  <= th1s_ff;
         d2_ff    <= d1_ff;
         dt2_2_ff <= dt2_1_ff;
         dtv2_ff  <= dtv1_ff;
      end
   end

   // stage 3: third products
   logic vld3_ff;
   logic signed [31:0] dkvdt3_ff, kw3_ff, h3_ff;
   logic signed [31:0] px3_ff, py3_ff, th3s_ff, nst3_ff, dtv3_ff, dtkv3_ff;
   always_ff @(posedge clock) begin
      if (reset) vld3_ff <= 1'b0;
      else if (advance) vld3_ff <= vld2_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         dkvdt3_ff <= lkm_pkg::mulq(d2_ff, dtkv2_ff, FRAC_BITS);
         kw3_ff    <= lkm_pkg::mulq(kvw2_ff, dt2_2_ff, FRAC_BITS);
         h3_ff     <= lkm_pkg::mulq(dt2_2_ff, kvv2_ff, FRAC_BITS);
         px3_ff    <= px2_ff;
         py3_ff    <= py2_ff;
         th3s_ff   <= th2s_ff;
         nst3_ff   <= nst2_ff;
         dtv3_ff   <= dtv2_ff;
         dtkv3_ff  <= dtkv2_ff;
      end
   end

   // stage 4: heading samples
   logic vld4_ff;
   logic signed [31:0] ang0_ff, ang1_ff, ang2_ff, ang3_ff;
   lkm_pkg::side_type side4_ff;
   logic signed [63:0] half_d, half_k, quart_k, th64;
   assign th64    = 64'(th3s_ff);
   assign half_d  = lkm_pkg::rshr(64'(dkvdt3_ff), 1);
   assign half_k  = lkm_pkg::rshr(64'(kw3_ff), 1);
   assign quart_k = lkm_pkg::rshr(64'(kw3_ff), 2);
   always_ff @(posedge clock) begin
      if (reset) vld4_ff <= 1'b0;
      else if (advance) vld4_ff <= vld3_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         ang0_ff <= th3s_ff;
         ang1_ff <= lkm_pkg::sat32(th64 + half_d);
         ang2_ff <= lkm_pkg::sat32(half_k + 64'(dkvdt3_ff) + th64);
         ang3_ff <= lkm_pkg::sat32(quart_k + half_d + th64);
         side4_ff.px     <= px3_ff;
         side4_ff.py     <= py3_ff;
         side4_ff.nsteer <= nst3_ff;
         side4_ff.dtv    <= dtv3_ff;
         side4_ff.dtkv   <= dtkv3_ff;
         side4_ff.h      <= h3_ff;
         side4_ff.th2    <= lkm_pkg::sat32(half_k + 64'(dkvdt3_ff) + th64);
      end
   end

   // four sine/cosine units
   logic signed [31:0] s0, c0, s1, c1, s2, c2, s3, c3;
   lkm_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic0 (
      .clock(clock), .ctl(ctl), .angle(ang0_ff), .sin_q30(s0), .cos_q30(c0));
   lkm_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic1 (
      .clock(clock), .ctl(ctl), .angle(ang1_ff), .sin_q30(s1), .cos_q30(c1));
   lkm_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic2 (
      .clock(clock), .ctl(ctl), .angle(ang2_ff), .sin_q30(s2), .cos_q30(c2));
   lkm_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic3 (
      .clock(clock), .ctl(ctl), .angle(ang3_ff), .sin_q30(s3), .cos_q30(c3));

   // side data and valid bits follow the cordic latency
   lkm_pkg::side_type side_ff [0:LAT-1];
   logic [LAT-1:0]    cvld_ff;
   always_ff @(posedge clock) begin
      if (reset) cvld_ff <= '0;
      else if (advance) cvld_ff <= {cvld_ff[LAT-2:0], vld4_ff};
   end
   always_ff @(posedge clock) begin
      if (advance) side_ff[0] <= side4_ff;
   end
   for (genvar i = 1; i < LAT; i++) begin : g_side
      always_ff @(posedge clock) begin
         if (advance) side_ff[i] <= side_ff[i-1];
      end
   end

   lkm_pkg::side_type sd;
   assign sd = side_ff[LAT-1];

   // stage 5: weighted sums prepared for divide by six, jacobian products
   logic vld5_ff;
   logic signed [34:0] csum, ssum;
   logic [32:0]        cmag_in, smag_in;
   logic [31:0]        chalf5_ff, shalf5_ff;
   logic               cneg5_ff, sneg5_ff;
   logic signed [63:0] jxh5_ff, jyh5_ff, jxs5_ff, jys5_ff;
   lkm_pkg::side_type  side5_ff;
   assign csum = 35'(c0) + (35'(c1) <<< 1) + 35'(c2) + (35'(c3) <<< 1);
   assign ssum = 35'(s0) + (35'(s1) <<< 1) + 35'(s2) + (35'(s3) <<< 1);
   assign cmag_in = (csum[34] ? 33'(-csum) : 33'(csum)) + 33'd3;
   assign smag_in = (ssum[34] ? 33'(-ssum) : 33'(ssum)) + 33'd3;
   always_ff @(posedge clock) begin
      if (reset) vld5_ff <= 1'b0;
      else if (advance) vld5_ff <= cvld_ff[LAT-1];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         chalf5_ff <= cmag_in[32:1];
         shalf5_ff <= smag_in[32:1];
         cneg5_ff  <= csum[34];
         sneg5_ff  <= ssum[34];
         jxh5_ff   <= 64'(sd.dtv) * 64'(-s0);
         jyh5_ff   <= 64'(sd.dtv) * 64'(c0);
         jxs5_ff   <= 64'(sd.h) * 64'(-s0);
         jys5_ff   <= 64'(sd.h) * 64'(c0);
         side5_ff  <= sd;
      end
   end

   // stage 6: divide by three through reciprocal, jacobian rounding
   logic vld6_ff;
   logic [64:0] cq6_ff, sq6_ff;
   logic        cneg6_ff, sneg6_ff;
   logic signed [31:0] jxh6_ff, jyh6_ff, jxs6_ff, jys6_ff;
   lkm_pkg::side_type  side6_ff;
   always_ff @(posedge clock) begin
      if (reset) vld6_ff <= 1'b0;
      else if (advance) vld6_ff <= vld5_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         cq6_ff   <= 65'(chalf5_ff) * 65'(lkm_pkg::DIV3_RECIP);
         sq6_ff   <= 65'(shalf5_ff) * 65'(lkm_pkg::DIV3_RECIP);
         cneg6_ff <= cneg5_ff;
         sneg6_ff <= sneg5_ff;
         jxh6_ff  <= lkm_pkg::sat32(lkm_pkg::rshr(jxh5_ff, 30));
         jyh6_ff  <= lkm_pkg::sat32(lkm_pkg::rshr(jyh5_ff, 30));
         jxs6_ff  <= lkm_pkg::sat32(lkm_pkg::rshr(jxs5_ff, 31));
         jys6_ff  <= lkm_pkg::sat32(lkm_pkg::rshr(jys5_ff, 31));
         side6_ff <= side5_ff;
      end
   end

   // stage 7: restore sign of the means
   logic vld7_ff;
   logic signed [31:0] cm7_ff, sm7_ff;
   logic signed [31:0] jxh7_ff, jyh7_ff, jxs7_ff, jys7_ff;
   lkm_pkg::side_type  side7_ff;
   logic signed [31:0] cq_in, sq_in;
   assign cq_in = $signed(cq6_ff[64:33]);
   assign sq_in = $signed(sq6_ff[64:33]);
   always_ff @(posedge clock) begin
      if (reset) vld7_ff <= 1'b0;
      else if (advance) vld7_ff <= vld6_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         cm7_ff   <= cneg6_ff ? -cq_in : cq_in;
         sm7_ff   <= sneg6_ff ? -sq_in : sq_in;
         jxh7_ff  <= jxh6_ff;
         jyh7_ff  <= jyh6_ff;
         jxs7_ff  <= jxs6_ff;
         jys7_ff  <= jys6_ff;
         side7_ff <= side6_ff;
      end
   end

   // stage 8: position increments
   logic vld8_ff;
   logic signed [63:0] px8_ff, py8_ff;
   logic signed [31:0] jxh8_ff, jyh8_ff, jxs8_ff, jys8_ff;
   lkm_pkg::side_type  side8_ff;
   always_ff @(posedge clock) begin
      if (reset) vld8_ff <= 1'b0;
      else if (advance) vld8_ff <= vld7_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         px8_ff   <= 64'(side7_ff.dtv) * 64'(cm7_ff);
         py8_ff   <= 64'(side7_ff.dtv) * 64'(sm7_ff);
         jxh8_ff  <= jxh7_ff;
         jyh8_ff  <= jyh7_ff;
         jxs8_ff  <= jxs7_ff;
         jys8_ff  <= jys7_ff;
         side8_ff <= side7_ff;
      end
   end

   // stage 9: output register
   logic             rsp_valid_ff;
   lkm_pkg::rsp_type rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= vld8_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.next_x <= lkm_pkg::sat32(64'(side8_ff.px) +
                                              lkm_pkg::rshr(px8_ff, 30));
         rsp_data_ff.next_y <= lkm_pkg::sat32(64'(side8_ff.py) +
                                              lkm_pkg::rshr(py8_ff, 30));
         rsp_data_ff.next_heading    <= side8_ff.th2;
         rsp_data_ff.next_steer      <= side8_ff.nsteer;
         rsp_data_ff.dx_dheading     <= jxh8_ff;
         rsp_data_ff.dx_dsteer       <= jxs8_ff;
         rsp_data_ff.dy_dheading     <= jyh8_ff;
         rsp_data_ff.dy_dsteer       <= jys8_ff;
         rsp_data_ff.dheading_dsteer <= side8_ff.dtkv;
      end
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // a stalled pipeline keeps every valid bit in place
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({vld1_ff, vld2_ff, vld3_ff, vld4_ff, cvld_ff,
                            vld5_ff, vld6_ff, vld7_ff, vld8_ff}))
      else $error("pipeline valid bits moved while stalled");

   // a register write lands in time_step
   assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready &&
       csr_paddr == lkm_pkg::ADDR_TIME_STEP) |=> dt_ff == $past(csr_pwdata[16:0]))
      else $error("time_step write lost");

   // outputs of the first cordic unit stay within unit range
   assert property (@(posedge clock) disable iff (reset)
      cvld_ff[LAT-1] |-> (c0 <= 32'sd1073741824 && c0 >= -32'sd1073741824 &&
                          s0 <= 32'sd1073741824 && s0 >= -32'sd1073741824))
      else $error("sine or cosine out of range");
`endif

endmodule

@@ tb/lateral_kinematic_model_step_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lateral_kinematic_model_step_test
// Self-checking bench for the kinematic model step pipeline: drives directed
// and random requests under several time steps and idle patterns, predicts
// every response in fixed point and compares it field by field.
// ---------------------------------------------------------------------------
module lateral_kinematic_model_step_test;

   localparam int FB = 16;
   localparam int DRAIN_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   lkm_pkg::req_type req_data;
   lkm_pkg::rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [lkm_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   int send_idle_pct, recv_stall_pct, hold_left, quiet_cycles;

   lateral_kinematic_model_step #(.FRAC_BITS(FB)) uut (.*);

   // fixed point helpers
   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return clamp32(round_shift(a * b, FB));
   endfunction

   function automatic longint sixth(longint n);
      if (n >= 0) return (n + 3) / 6;
      return -((-n + 3) / 6);
   endfunction

   // cordic sine and cosine in q30
   function automatic void sin_cos(input longint ang, output longint s, output longint c);
      logic [63:0] prod;
      logic [31:0] phase;
      longint x, y, z, nx;
      prod = ang * 64'sd683565276;
      phase = prod[FB+31:FB];
      z = longint'(phase[29:0]);
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < lkm_pkg::CORDIC_ITERS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(lkm_pkg::ATAN_TURN[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(lkm_pkg::ATAN_TURN[i]);
         end
         x = nx;
      end
      if (x > 64'sd1073741824) x = 64'sd1073741824;
      if (x < -64'sd1073741824) x = -64'sd1073741824;
      if (y > 64'sd1073741824) y = 64'sd1073741824;
      if (y < -64'sd1073741824) y = -64'sd1073741824;
      case (phase[31:30])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // one model step with its jacobian entries
   function automatic lkm_pkg::rsp_type model_step(lkm_pkg::req_type r, logic [16:0] step);
      longint dt, kv, dtkv, dkvdt, dt2, kwvdt2, dtv, th1, th2, th3, h, cm, sm;
      longint s0, c0, s1, c1, s2, c2, s3, c3;
      lkm_pkg::rsp_type o;
      dt = longint'(step);
      kv = qmul(r.curv_gain, r.ref_vel);
      dtkv = qmul(dt, kv);
      dkvdt = qmul(r.steer_angle, dtkv);
      dt2 = qmul(dt, dt);
      kwvdt2 = qmul(qmul(kv, r.steer_rate), dt2);
      dtv = qmul(dt, r.ref_vel);
      th1 = clamp32(r.heading + round_shift(dkvdt, 1));
      th2 = clamp32(round_shift(kwvdt2, 1) + dkvdt + r.heading);
      th3 = clamp32(round_shift(kwvdt2, 2) + round_shift(dkvdt, 1) + r.heading);
      sin_cos(r.heading, s0, c0);
      sin_cos(th1, s1, c1);
      sin_cos(th2, s2, c2);
      sin_cos(th3, s3, c3);
      cm = sixth(c0 + 2 * c1 + c2 + 2 * c3);
      sm = sixth(s0 + 2 * s1 + s2 + 2 * s3);
      h = qmul(dt2, qmul(kv, r.ref_vel));
      o.next_x = 32'(clamp32(r.pos_x + round_shift(dtv * cm, 30)));
      o.next_y = 32'(clamp32(r.pos_y + round_shift(dtv * sm, 30)));
      o.next_heading = 32'(th2);
      o.next_steer = 32'(clamp32(r.steer_angle + qmul(dt, r.steer_rate)));
      o.dx_dheading = 32'(clamp32(round_shift(dtv * -s0, 30)));
      o.dx_dsteer = 32'(clamp32(round_shift(h * -s0, 31)));
      o.dy_dheading = 32'(clamp32(round_shift(dtv * c0, 30)));
      o.dy_dsteer = 32'(clamp32(round_shift(h * c0, 31)));
      o.dheading_dsteer = 32'(dtkv);
      return o;
   endfunction

   // predicted responses in order, compared against the block
   class step_scoreboard;
      lkm_pkg::rsp_type pending[$];
      logic [16:0] time_step;
      int errors;

      function new();
         time_step = lkm_pkg::TIME_STEP_RESET;
         errors = 0;
      endfunction

      function void note_request(lkm_pkg::req_type r);
         pending.push_back(model_step(r, time_step));
      endfunction

      function void check_result(lkm_pkg::rsp_type got);
         lkm_pkg::rsp_type want;
         string names[9] = '{"next_x", "next_y", "next_heading", "next_steer",
            "dx_dheading", "dx_dsteer", "dy_dheading", "dy_dsteer", "dheading_dsteer"};
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", got);
            return;
         end
         want = pending.pop_front();
         for (int i = 0; i < 9; i++) begin
            if (got[287-32*i -: 32] !== want[287-32*i -: 32]) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch %s: expected %h actual %h", names[i],
                           want[287-32*i -: 32], got[287-32*i -: 32]);
            end
         end
      endfunction
   endclass

   step_scoreboard sb = new();

   // clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // receiver stalls, with an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic csr_write(logic [16:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= lkm_pkg::ADDR_TIME_STEP;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      sb.time_step = value;
   endtask

   // wait at least one edge so the last accepted request is already noted
   task automatic wait_drained();
      do @(posedge clock); while (sb.pending.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_request(lkm_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [31:0] rand_span(int unsigned half);
      return $signed($urandom_range(2 * half)) - $signed(half);
   endfunction

   // plausible driving state or raw noise
   function automatic lkm_pkg::req_type random_request();
      lkm_pkg::req_type r;
      if ($urandom_range(99) < 75) begin
         r.pos_x = rand_span(32'h4000_0000);
         r.pos_y = rand_span(32'h4000_0000);
         r.heading = rand_span(32'h0018_0000);
         r.steer_angle = rand_span(32'h0000_c000);
         r.steer_rate = rand_span(32'h0002_0000);
         r.ref_vel = rand_span(32'h0028_0000);
         r.curv_gain = rand_span(32'h0002_0000);
      end else begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end
      return r;
   endfunction

   task automatic run_phase(int count, int idle_mode, bit pressure);
      case (idle_mode)
         0: begin send_idle_pct = 0; recv_stall_pct = 0; end
         1: begin send_idle_pct = 50; recv_stall_pct = 0; end
         2: begin send_idle_pct = 0; recv_stall_pct = 50; end
         default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int n = 0; n < count; n++) begin
         if (pressure && n == 20) hold_left = 300;
         // sender pause until the pipe is empty
         if (pressure && n == count / 2) begin
            req_valid <= 0;
            do @(posedge clock); while (sb.pending.size() != 0);
         end
         send_request(random_request());
      end
      req_valid <= 0;
      wait_drained();
   endtask

   initial begin
      lkm_pkg::req_type dir[$];
      lkm_pkg::req_type r;
      logic [16:0] steps[8] = '{17'd1, 17'd65536, 17'd6554, 17'd0,
                                17'd32768, 17'd65536, 17'd1, 17'd6554};
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 0;
      quiet_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: zeros, extremes, large angles, saturating products
      dir.push_back('0);
      dir.push_back({7{32'h7fff_ffff}});
      dir.push_back({7{32'h8000_0000}});
      dir.push_back({7{32'hffff_ffff}});
      dir.push_back({7{32'h0000_0001}});
      for (int q = 0; q < 8; q++) begin
         r = '0;
         r.heading = 32'sd51472 * q;
         r.ref_vel = 32'sd655360;
         r.curv_gain = 32'sd65536;
         r.steer_angle = 32'sd6554;
         r.steer_rate = -32'sd13107;
         dir.push_back(r);
      end
      r = '0;
      r.heading = 32'h7fff_ffff;
      r.ref_vel = 32'h7fff_ffff;
      r.curv_gain = 32'h7fff_ffff;
      r.steer_angle = 32'h7fff_ffff;
      r.steer_rate = 32'h7fff_ffff;
      dir.push_back(r);
      r.pos_x = 32'h7fff_ff00;
      r.pos_y = 32'h8000_0100;
      r.ref_vel = 32'h8000_0000;
      r.heading = 32'h8000_0000;
      dir.push_back(r);
      r = '0;
      r.heading = -32'sd411775;
      r.pos_x = 32'h7fff_fff0;
      r.pos_y = 32'h8000_0010;
      r.ref_vel = 32'sd2621440;
      dir.push_back(r);
      foreach (dir[i]) send_request(dir[i]);
      req_valid <= 0;
      wait_drained();

      // random phases over several time steps and idle patterns
      for (int p = 0; p < 8; p++) begin
         csr_write(p == 4 ? 17'($urandom_range(1, 65536)) : steps[p]);
         run_phase(200, p % 4, p == 0 || p == 6);
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
